### hdl/orse_pkg.sv
// ----------------------------------------------------------------------------
// orse_pkg
// Shared types and constants for the search ROM decision engine.
// ----------------------------------------------------------------------------
package orse_pkg;

  localparam int unsigned CODE_BITS_DEF = 64;
  localparam int unsigned ROM_W         = 64;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned DIFF_W        = 8;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_BIT   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_MORE     = 2'd0,
    ST_LAST     = 2'd1,
    ST_NO_PRES  = 2'd2,
    ST_DATA_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic              func;
    logic              presence;
    logic [DIFF_W-1:0] start_diff;
    logic              id_bit;
    logic              cmp_bit;
  } item_t;

  typedef struct packed {
    logic             send_valid;
    logic             send_bit;
    logic             done_res;
    logic [1:0]       status;
    logic [POS_W-1:0] next_branch;
    logic [ROM_W-1:0] rom_code;
  } res_t;

endpackage

### hdl/orse_decide.sv
// ----------------------------------------------------------------------------
// orse_decide
// Pass state and per-beat direction decision; result is combinational.
// ----------------------------------------------------------------------------
module orse_decide #(
  parameter int unsigned CODE_BITS = orse_pkg::CODE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  orse_pkg::item_t item_i,
  output orse_pkg::res_t  res_o
);
  import orse_pkg::*;

  logic [CODE_BITS-1:0] code_q, code_d;
  logic [POS_W-1:0]     cnt_q, cnt_d;
  logic [DIFF_W-1:0]    bprev_q, bprev_d;
  logic [POS_W-1:0]     bnext_q, bnext_d;
  logic                 pass_q, pass_d;

  logic                 dir_bit;
  logic                 take_one;
  logic [POS_W-1:0]     cnt_dec;
  logic [DIFF_W-1:0]    pos_ext;

  assign cnt_dec = cnt_q - POS_W'(1);
  assign pos_ext = DIFF_W'(cnt_q);

  // conflict rule: go 1 below the old branch, or follow an old 1 off the branch
  assign take_one = (bprev_q > pos_ext) || (code_q[0] && (bprev_q != pos_ext));
  assign dir_bit  = (!item_i.id_bit && !item_i.cmp_bit) ? take_one : item_i.id_bit;

  always_comb begin
    code_d  = code_q;
    cnt_d   = cnt_q;
    bprev_d = bprev_q;
    bnext_d = bnext_q;
    pass_d  = pass_q;
    res_o   = '0;

    if (item_i.func == FUNC_START) begin
      if (!item_i.presence) begin
        pass_d         = 1'b0;
        res_o.done_res = 1'b1;
        res_o.status   = ST_NO_PRES;
      end else begin
        pass_d  = 1'b1;
        cnt_d   = POS_W'(CODE_BITS);
        bprev_d = item_i.start_diff;
        bnext_d = '0;
      end
    end else if (pass_q) begin
      if (item_i.id_bit && item_i.cmp_bit) begin
        pass_d         = 1'b0;
        res_o.done_res = 1'b1;
        res_o.status   = ST_DATA_ERR;
      end else begin
        if (!item_i.id_bit && !item_i.cmp_bit && take_one) begin
          bnext_d = cnt_q;
        end
        code_d           = {dir_bit, code_q[CODE_BITS-1:1]};
        cnt_d            = cnt_dec;
        res_o.send_valid = 1'b1;
        res_o.send_bit   = dir_bit;
        if (cnt_dec == '0) begin
          pass_d            = 1'b0;
          res_o.done_res    = 1'b1;
          res_o.status      = (bnext_d != '0) ? ST_MORE : ST_LAST;
          res_o.next_branch = bnext_d;
        end
      end
    end
    res_o.rom_code = ROM_W'(code_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      cnt_q   <= '0;
      bprev_q <= '0;
      bnext_q <= '0;
      pass_q  <= 1'b0;
    end else if (acc_i) begin
      code_q  <= code_d;
      cnt_q   <= cnt_d;
      bprev_q <= bprev_d;
      bnext_q <= bnext_d;
      pass_q  <= pass_d;
    end
  end

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q |-> (cnt_q != '0))
    else $error("pass running with zero bit position");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && item_i.func == FUNC_BIT && pass_q && !(item_i.id_bit && item_i.cmp_bit))
    |=> (cnt_q == $past(cnt_q) - POS_W'(1)))
    else $error("bit position did not step down");

  a_bnext_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnext_q <= POS_W'(CODE_BITS))
    else $error("branch position beyond code length");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && item_i.func == FUNC_START && item_i.presence)
    |=> (pass_q && cnt_q == POS_W'(CODE_BITS) && bnext_q == '0))
    else $error("start beat did not open a pass");

endmodule

### hdl/orse_out_reg.sv
// ----------------------------------------------------------------------------
// orse_out_reg
// Result register; takes a new beat whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module orse_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  orse_pkg::res_t  res_i,
  input  logic           out_ready_i,
  output logic           can_load_o,
  output logic           out_valid_o,
  output orse_pkg::res_t  res_o
);
  import orse_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign can_load_o  = !valid_q || out_ready_i;
  assign valid_d     = load_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !load_i)
    else $error("result beat overwritten while stalled");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded beat not presented");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(res_q)))
    else $error("stalled result changed");

endmodule

### hdl/onewire_rom_search_engine.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// Direction decision for a search ROM pass; one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// result: a result beat appears in the cycle after its input beat is taken
// throughput: one beat per cycle unless stalled; the single result register is the only stage
// in_ready_o stays high while the result register is empty or being drained
// reset: pass idle, code register, bit position and branch positions cleared
module onewire_rom_search_engine #(
  parameter int unsigned CODE_BITS = orse_pkg::CODE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic                            presence_i,
  input  logic [orse_pkg::DIFF_W-1:0]     start_diff_i,
  input  logic                            id_bit_i,
  input  logic                            cmp_bit_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            send_valid_o,
  output logic                            send_bit_o,
  output logic                            done_res_o,
  output logic [1:0]                      status_o,
  output logic [orse_pkg::POS_W-1:0]      next_branch_o,
  output logic [orse_pkg::ROM_W-1:0]      rom_code_o
);
  import orse_pkg::*;

  item_t item;
  res_t  res_c;
  res_t  res_r;
  logic  acc;
  logic  can_load;

  assign item.func       = func_i;
  assign item.presence   = presence_i;
  assign item.start_diff = start_diff_i;
  assign item.id_bit     = id_bit_i;
  assign item.cmp_bit    = cmp_bit_i;

  assign in_ready_o = can_load;
  assign acc        = in_valid_i && can_load;

  orse_decide #(
    .CODE_BITS (CODE_BITS)
  ) u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (item),
    .res_o  (res_c)
  );

  orse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc),
    .res_i       (res_c),
    .out_ready_i (out_ready_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .res_o       (res_r)
  );

  assign send_valid_o  = res_r.send_valid;
  assign send_bit_o    = res_r.send_bit;
  assign done_res_o    = res_r.done_res;
  assign status_o      = res_r.status;
  assign next_branch_o = res_r.next_branch;
  assign rom_code_o    = res_r.rom_code;

endmodule
